// ===== sv/quasi_clique_graph_checker_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the quasi-clique graph checker
// Implication checks on the same clock edge and on the next one. They can be
// compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef QUASI_CLIQUE_GRAPH_CHECKER_ASSERT_SVH
`define QUASI_CLIQUE_GRAPH_CHECKER_ASSERT_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent on the same edge
`define QCGC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("qcgc assertion failed");
// antecedent implies consequent on the following edge
`define QCGC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("qcgc assertion failed");
`else
`define QCGC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define QCGC_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/qcgc_pkg.sv =====
// ---------------------------------------------------------------------------
// qcgc_pkg
// Beat types, action codes, register indexes and constants of the
// quasi-clique graph checker.
// ---------------------------------------------------------------------------
`default_nettype none

package qcgc_pkg;

	// defaults and fixed widths
	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEG_W            = 7;
	localparam int GAMMA_W          = 17;
	localparam int MIN_MEMBERS_W    = 7;
	localparam int CFG_IDX_W        = 1;

	localparam logic [DEG_W-1:0]         DEG_MAX           = 7'd127;
	localparam logic [GAMMA_W-1:0]       GAMMA_RESET       = 17'd32768;
	localparam logic [MIN_MEMBERS_W-1:0] MIN_MEMBERS_RESET = 7'd1;

	// action codes
	localparam logic [2:0] ACT_CLEAR  = 3'd0;
	localparam logic [2:0] ACT_ADD_V  = 3'd1;
	localparam logic [2:0] ACT_ADD_E  = 3'd2;
	localparam logic [2:0] ACT_REM_V  = 3'd3;
	localparam logic [2:0] ACT_QUERY  = 3'd4;
	localparam logic [2:0] ACT_TEST   = 3'd5;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GAMMA       = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_MEMBERS = 1'd1;

	typedef struct packed {
		logic [2:0] action;
		logic [5:0] vertex_a;
		logic [5:0] vertex_b;
	} item_t;

	typedef struct packed {
		logic [DEG_W-1:0] degree;
		logic             is_quasi_clique;
	} result_t;

endpackage

`default_nettype wire

// ===== sv/quasi_clique_graph_checker.sv =====
// ---------------------------------------------------------------------------
// quasi_clique_graph_checker
// Directed graph store with membership, per-vertex degree and adjacency rows
// in one synchronous memory; answers degree queries and gamma quasi-clique
// tests.
// ---------------------------------------------------------------------------
//  channel | beat signals                               | notes
//  item    | item_valid, item_stall, item               | in, stall driven here
//  result  | result_valid, result_stall, result         | out, stall from sink
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data  | in, ready always high
//
//  One entry per vertex {member, degree, row} sits in a one-port-read,
//  one-port-write memory. Add vertex and degree query read the entry of
//  vertex_a; add edge reads the entry of vertex_b, then that of vertex_a.
//  Unused codes and a test decided by the member count alone go straight to
//  the result. Clear writes every entry; remove and a full test sweep them.
//  After reset a clearing pass holds item_stall high.
//  item_stall is high whenever the sequencer is busy; a finished
//  result waits in the output register while the next item beat is
//  accepted, and a second result waits for it to drain.
// ---------------------------------------------------------------------------
`default_nettype none

module quasi_clique_graph_checker #(
	parameter int MAX_VERTICES = qcgc_pkg::DEF_MAX_VERTICES
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  item_valid,
	output logic                                 item_stall,
	input  qcgc_pkg::item_t                      item,
	output logic                                 result_valid,
	input  wire                                  result_stall,
	output qcgc_pkg::result_t                    result,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [qcgc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [qcgc_pkg::GAMMA_W-1:0]         cfg_data
);

	import qcgc_pkg::*;

	localparam int AW     = $clog2(MAX_VERTICES);
	localparam int CW     = $clog2(MAX_VERTICES + 1);
	localparam int EW     = 1 + DEG_W + MAX_VERTICES;
	localparam int PW     = GAMMA_W + CW;
	localparam int NEED_W = CW + 2;

	localparam logic [3:0] ST_INIT = 4'd0;
	localparam logic [3:0] ST_IDLE = 4'd1;
	localparam logic [3:0] ST_RD_B = 4'd2;
	localparam logic [3:0] ST_RD_A = 4'd3;
	localparam logic [3:0] ST_CLR  = 4'd4;
	localparam logic [3:0] ST_REM  = 4'd5;
	localparam logic [3:0] ST_NEED = 4'd6;
	localparam logic [3:0] ST_TEST = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	// control and datapath registers
	logic [3:0]               state_q;
	logic [2:0]               act_q;
	logic [AW-1:0]            a_q;
	logic [AW-1:0]            b_q;
	logic                     b_member_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            sweep_q;
	logic                     vld_s1;
	logic [AW-1:0]            addr_s1;
	logic [NEED_W-1:0]        need_q;
	logic                     fail_q;
	logic [DEG_W-1:0]         res_deg_q;
	logic                     res_qc_q;
	logic                     out_valid_q;
	result_t                  out_q;
	logic [GAMMA_W-1:0]       gamma_q;
	logic [MIN_MEMBERS_W-1:0] min_members_q;

	// memory
	logic [EW-1:0]         mem [MAX_VERTICES];
	logic [EW-1:0]         rdata_q;
	logic                  mem_re;
	logic [AW-1:0]         mem_ra;
	logic                  mem_we;
	logic [AW-1:0]         mem_wa;
	logic [EW-1:0]         mem_wd;

	// decoded entry and misc
	logic                    rd_member;
	logic [DEG_W-1:0]        rd_deg;
	logic [MAX_VERTICES-1:0] rd_row;
	logic                    accept;
	logic                    in_a_ok;
	logic                    in_b_ok;
	logic                    sweep_end;
	logic                    edge_ok;
	logic                    out_free;
	logic [PW-1:0]           prod;
	logic [PW:0]             need_sum;

	assign rd_member = rdata_q[EW-1];
	assign rd_deg    = rdata_q[EW-2 -: DEG_W];
	assign rd_row    = rdata_q[MAX_VERTICES-1:0];

	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign in_a_ok      = (32'(item.vertex_a) < MAX_VERTICES);
	assign in_b_ok      = (32'(item.vertex_b) < MAX_VERTICES);
	assign sweep_end    = (sweep_q == CW'(MAX_VERTICES));
	assign edge_ok      = rd_member && b_member_q && !rd_row[b_q];
	assign out_free     = !out_valid_q || !result_stall;
	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign result       = out_q;

	// threshold: ceil(gamma * (n - 1)) in Q1.16
	assign prod     = PW'(gamma_q) * PW'(count_q - CW'(1));
	assign need_sum = (PW + 1)'(prod) + (PW + 1)'(17'd65535);

	// memory port control
	always_comb begin
		mem_re = 1'b0;
		mem_ra = a_q;
		mem_we = 1'b0;
		mem_wa = a_q;
		mem_wd = rdata_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((item.action == ACT_ADD_V || item.action == ACT_QUERY) && in_a_ok) begin
						mem_re = 1'b1;
						mem_ra = AW'(item.vertex_a);
					end else if (item.action == ACT_ADD_E && in_a_ok && in_b_ok) begin
						mem_re = 1'b1;
						mem_ra = AW'(item.vertex_b);
					end
				end
			end
			ST_RD_B: begin
				mem_re = 1'b1;
			end
			ST_RD_A: begin
				if (act_q == ACT_ADD_V && !rd_member) begin
					mem_we        = 1'b1;
					mem_wd[EW-1]  = 1'b1;
				end else if (act_q == ACT_ADD_E && edge_ok) begin
					mem_we                  = 1'b1;
					mem_wd[b_q]             = 1'b1;
					mem_wd[EW-2 -: DEG_W]   = (rd_deg == DEG_MAX) ? rd_deg : rd_deg + 7'd1;
				end
			end
			ST_INIT, ST_CLR: begin
				mem_we = !sweep_end;
				mem_wa = sweep_q[AW-1:0];
				mem_wd = '0;
			end
			ST_REM: begin
				mem_re = !sweep_end;
				mem_ra = sweep_q[AW-1:0];
				mem_wa = addr_s1;
				if (vld_s1 && rd_member) begin
					if (addr_s1 == a_q) begin
						mem_we       = 1'b1;
						mem_wd[EW-1] = 1'b0;
					end else if (rd_row[a_q]) begin
						mem_we                = 1'b1;
						mem_wd[a_q]           = 1'b0;
						mem_wd[EW-2 -: DEG_W] = (rd_deg == '0) ? rd_deg : rd_deg - 7'd1;
					end
				end
			end
			ST_TEST: begin
				mem_re = !sweep_end;
				mem_ra = sweep_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// entry memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_ra];
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gamma_q       <= GAMMA_RESET;
			min_members_q <= MIN_MEMBERS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_GAMMA) begin
				gamma_q <= cfg_data;
			end else begin
				min_members_q <= cfg_data[MIN_MEMBERS_W-1:0];
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			sweep_q    <= '0;
			vld_s1     <= 1'b0;
			addr_s1    <= '0;
			count_q    <= '0;
			act_q      <= ACT_CLEAR;
			a_q        <= '0;
			b_q        <= '0;
			b_member_q <= 1'b0;
			need_q     <= '0;
			fail_q     <= 1'b0;
			res_deg_q  <= '0;
			res_qc_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_INIT, ST_CLR: begin
					if (!sweep_end) begin
						sweep_q <= sweep_q + CW'(1);
					end else begin
						count_q <= '0;
						state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						act_q     <= item.action;
						a_q       <= AW'(item.vertex_a);
						b_q       <= AW'(item.vertex_b);
						res_deg_q <= '0;
						// an empty member set passes only with a zero minimum
						res_qc_q  <= (item.action == ACT_TEST) && (count_q == '0) &&
							(min_members_q == '0);
						sweep_q   <= '0;
						vld_s1    <= 1'b0;
						case (item.action)
							ACT_CLEAR: state_q <= ST_CLR;
							ACT_ADD_V, ACT_QUERY: begin
								state_q <= in_a_ok ? ST_RD_A : ST_DONE;
							end
							ACT_ADD_E: begin
								state_q <= (in_a_ok && in_b_ok) ? ST_RD_B : ST_DONE;
							end
							ACT_REM_V: begin
								state_q <= in_a_ok ? ST_REM : ST_DONE;
							end
							ACT_TEST: begin
								if (32'(count_q) < 32'(min_members_q) || count_q == '0) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_NEED;
								end
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_RD_B: begin
					b_member_q <= rd_member;
					state_q    <= ST_RD_A;
				end
				ST_RD_A: begin
					if (act_q == ACT_ADD_V && !rd_member) begin
						count_q <= count_q + CW'(1);
					end
					if (act_q == ACT_QUERY) begin
						res_deg_q <= rd_deg;
					end
					state_q <= ST_DONE;
				end
				ST_NEED: begin
					need_q  <= need_sum[PW:16];
					fail_q  <= 1'b0;
					state_q <= ST_TEST;
				end
				ST_REM, ST_TEST: begin
					vld_s1  <= !sweep_end;
					addr_s1 <= sweep_q[AW-1:0];
					if (!sweep_end) begin
						sweep_q <= sweep_q + CW'(1);
					end
					// entry in stage 1
					if (vld_s1 && rd_member) begin
						if (state_q == ST_REM && addr_s1 == a_q) begin
							count_q <= count_q - CW'(1);
						end
						if (state_q == ST_TEST && 32'(rd_deg) < 32'(need_q)) begin
							fail_q <= 1'b1;
						end
					end
					if (sweep_end && !vld_s1) begin
						res_qc_q <= (state_q == ST_TEST) && !fail_q;
						state_q  <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload register
	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_q.degree          <= res_deg_q;
			out_q.is_quasi_clique <= res_qc_q;
		end
	end

	`include "quasi_clique_graph_checker_assert.svh"

	`QCGC_ASSERT_IMP(a_count_bound, clk, arst_n, state_q == ST_IDLE, 32'(count_q) <= MAX_VERTICES)
	`QCGC_ASSERT_NXT(a_done_emits, clk, arst_n, state_q == ST_DONE && out_free, result_valid)
	`QCGC_ASSERT_IMP(a_rem_write_s1, clk, arst_n, mem_we && state_q == ST_REM, vld_s1)

endmodule

`default_nettype wire

// ===== tb/tb_quasi_clique_graph_checker.sv =====
// ---------------------------------------------------------------------------
// tb_quasi_clique_graph_checker
// Self-checking bench for the quasi-clique graph checker. A local graph
// tracker predicts the degree and quasi-clique flag of every item beat. The
// result beats are compared in order against that prediction. Directed
// corner cases and a register sweep run first. Random graph episodes follow:
// clear, add vertices, add edges, then remove, re-add, query and test, with
// random idle on both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_quasi_clique_graph_checker;
	import qcgc_pkg::*;

	localparam int NV = DEF_MAX_VERTICES;
	// action codes the block does not use
	localparam logic [2:0] ACT_SPARE_6 = 3'd6;
	localparam logic [2:0] ACT_SPARE_7 = 3'd7;
	localparam logic [GAMMA_W-1:0] GAMMA_ONE = 17'd65536;
	localparam logic [GAMMA_W-1:0] GAMMA_TOP = 17'h1FFFF;
	localparam int TARGET_ITEMS = 1400;
	localparam int QUIET_LIMIT  = 4000;
	localparam int TAIL_CYCLES  = 80;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 item_valid   = 1'b0;
	logic                 item_stall;
	item_t                item         = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	result_t              result;
	logic                 cfg_valid    = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [GAMMA_W-1:0]   cfg_data     = '0;

	// graph tracker state
	logic                     graph_member [NV];
	logic [NV-1:0]            graph_row    [NV];
	logic [DEG_W-1:0]         graph_degree [NV];
	logic [6:0]               graph_members;
	logic [GAMMA_W-1:0]       cfg_gamma;
	logic [MIN_MEMBERS_W-1:0] cfg_min_members;

	result_t pending_results[$];
	int      chosen[$];
	int      error_count  = 0;
	int      items_sent   = 0;
	int      idle_pct     = 30;
	int      quiet_cycles = 0;

	quasi_clique_graph_checker i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// graph tracker
	// ------------------------------------------------------------------
	function automatic void wipe_graph_model();
		for (int i = 0; i < NV; i++) begin
			graph_member[i] = 1'b0;
			graph_row[i]    = '0;
			graph_degree[i] = '0;
		end
		graph_members = '0;
	endfunction

	function automatic logic passes_density_test();
		longint unsigned need;
		if (graph_members < cfg_min_members)
			return 1'b0;
		if (graph_members == 0)
			return 1'b1;
		// ceil(gamma * (n-1)) in Q1.16
		need = (64'(cfg_gamma) * 64'(graph_members - 7'd1) + 64'd65535) >> 16;
		for (int i = 0; i < NV; i++)
			if (graph_member[i] && 64'(graph_degree[i]) < need)
				return 1'b0;
		return 1'b1;
	endfunction

	function automatic result_t apply_item(item_t beat);
		result_t     r;
		int unsigned va;
		int unsigned vb;
		r  = '0;
		va = beat.vertex_a;
		vb = beat.vertex_b;
		case (beat.action)
			ACT_CLEAR: wipe_graph_model();
			ACT_ADD_V: begin
				if (!graph_member[va]) begin
					graph_member[va] = 1'b1;
					graph_members++;
				end
			end
			ACT_ADD_E: begin
				if (graph_member[va] && graph_member[vb] && !graph_row[va][vb]) begin
					graph_row[va][vb] = 1'b1;
					if (graph_degree[va] < DEG_MAX)
						graph_degree[va]++;
				end
			end
			ACT_REM_V: begin
				if (graph_member[va]) begin
					graph_member[va] = 1'b0;
					graph_members--;
				end
				// drop in-edges from the remaining members only
				for (int i = 0; i < NV; i++) begin
					if (graph_member[i] && graph_row[i][va]) begin
						graph_row[i][va] = 1'b0;
						if (graph_degree[i] > 0)
							graph_degree[i]--;
					end
				end
			end
			ACT_QUERY: r.degree = graph_degree[va];
			ACT_TEST:  r.is_quasi_clique = passes_density_test();
			default: ;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// result side: random stall, in-order check
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < idle_pct);
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result beat with nothing pending: degree %0d flag %0b",
					result.degree, result.is_quasi_clique));
			end else begin
				want = pending_results.pop_front();
				if (result.degree !== want.degree)
					report_mismatch($sformatf("degree %0d, expected %0d",
						result.degree, want.degree));
				if (result.is_quasi_clique !== want.is_quasi_clique)
					report_mismatch($sformatf("quasi-clique flag %0b, expected %0b",
						result.is_quasi_clique, want.is_quasi_clique));
			end
		end
	end

	// watchdog: cycles without any beat on any channel
	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("quasi_clique_graph_checker verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------
	// item and register drivers
	// ------------------------------------------------------------------
	task automatic send_item(input logic [2:0] act, input logic [5:0] va, input logic [5:0] vb);
		item_t beat;
		beat.action   = act;
		beat.vertex_a = va;
		beat.vertex_b = vb;
		if ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		item_valid <= 1'b1;
		item       <= beat;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		pending_results.push_back(apply_item(beat));
		items_sent++;
	endtask

	task automatic wait_for_drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAMMA_W-1:0] value);
		wait_for_drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_GAMMA)
			cfg_gamma = value;
		else
			cfg_min_members = value[MIN_MEMBERS_W-1:0];
	endtask

	// clear, add about count vertices, then edges from them
	task automatic build_graph(input int count, input int density);
		int v;
		chosen.delete();
		send_item(ACT_CLEAR, 6'($urandom), 6'($urandom));
		repeat (count) begin
			v = $urandom_range(NV - 1);
			if (!graph_member[v])
				chosen.push_back(v);
			send_item(ACT_ADD_V, 6'(v), 6'($urandom));
		end
		if (chosen.size() <= 12) begin
			foreach (chosen[i])
				foreach (chosen[j])
					if ($urandom_range(99) < density)
						send_item(ACT_ADD_E, 6'(chosen[i]), 6'(chosen[j]));
		end else begin
			repeat (2 * chosen.size())
				send_item(ACT_ADD_E, 6'(chosen[$urandom_range(chosen.size() - 1)]),
					6'($urandom));
		end
	endtask

	// one graph, then a few edits each followed by a test
	task automatic run_graph_episode();
		int count;
		int density;
		int v;
		int removed;
		removed = -1;
		count = ($urandom_range(19) == 0) ? $urandom_range(13, NV) : $urandom_range(1, 10);
		case ($urandom_range(3))
			0:       density = 100;
			1:       density = 85;
			2:       density = 60;
			default: density = 30;
		endcase
		build_graph(count, density);
		send_item(ACT_TEST, 6'($urandom), 6'($urandom));
		repeat ($urandom_range(2, 6)) begin
			v = chosen[$urandom_range(chosen.size() - 1)];
			case ($urandom_range(5))
				0: send_item(ACT_QUERY, 6'(v), 6'($urandom));
				1: begin
					send_item(ACT_REM_V, 6'(v), 6'($urandom));
					removed = v;
				end
				2: begin
					if (removed >= 0)
						send_item(ACT_ADD_V, 6'(removed), 6'($urandom));
					else
						send_item(ACT_ADD_V, 6'($urandom), 6'($urandom));
				end
				3: send_item(ACT_ADD_E, 6'(v), 6'(chosen[$urandom_range(chosen.size() - 1)]));
				4: send_item(3'($urandom), 6'($urandom), 6'($urandom));
				default: send_item(ACT_QUERY, 6'($urandom), 6'($urandom));
			endcase
			send_item(ACT_TEST, 6'($urandom), 6'($urandom));
		end
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_directed_cases();
		// empty graph under reset registers
		send_item(ACT_TEST, 6'd0, 6'd0);
		send_item(ACT_QUERY, 6'd0, 6'd63);
		send_item(ACT_QUERY, 6'd63, 6'd0);
		// add the end vertices, the second one twice
		send_item(ACT_ADD_V, 6'd0, 6'd0);
		send_item(ACT_ADD_V, 6'd63, 6'd63);
		send_item(ACT_ADD_V, 6'd63, 6'd0);
		// new, reverse, duplicate, self and non-member edges
		send_item(ACT_ADD_E, 6'd0, 6'd63);
		send_item(ACT_ADD_E, 6'd63, 6'd0);
		send_item(ACT_ADD_E, 6'd0, 6'd63);
		send_item(ACT_ADD_E, 6'd0, 6'd0);
		send_item(ACT_ADD_E, 6'd63, 6'd5);
		send_item(ACT_ADD_E, 6'd5, 6'd0);
		send_item(ACT_QUERY, 6'd0, 6'd0);
		send_item(ACT_QUERY, 6'd63, 6'd0);
		send_item(ACT_TEST, 6'd63, 6'd63);
		// remove a non-member, then a member; removed vertex keeps its degree
		send_item(ACT_REM_V, 6'd5, 6'd0);
		send_item(ACT_REM_V, 6'd63, 6'd0);
		send_item(ACT_QUERY, 6'd63, 6'd0);
		send_item(ACT_QUERY, 6'd0, 6'd0);
		// re-add restores the kept row
		send_item(ACT_ADD_V, 6'd63, 6'd0);
		send_item(ACT_TEST, 6'd0, 6'd0);
		// spare action codes
		send_item(ACT_SPARE_6, 6'd63, 6'd63);
		send_item(ACT_SPARE_7, 6'd63, 6'd63);
		send_item(ACT_CLEAR, 6'd63, 6'd63);
		send_item(ACT_TEST, 6'd0, 6'd0);
		// empty set passes once the minimum member count is zero
		write_reg(CFG_MIN_MEMBERS, '0);
		send_item(ACT_TEST, 6'd0, 6'd0);
	endtask

	task automatic test_register_sweep();
		logic [GAMMA_W-1:0]       gammas [6];
		logic [MIN_MEMBERS_W-1:0] mins   [6];
		gammas = '{17'd0, 17'd1, 17'd32768, 17'd65535, GAMMA_ONE, GAMMA_TOP};
		mins   = '{7'd0, 7'd2, 7'd3, 7'd4, 7'd1, 7'd5};
		foreach (gammas[i]) begin
			write_reg(CFG_GAMMA, gammas[i]);
			write_reg(CFG_MIN_MEMBERS, 17'(mins[i]));
			build_graph(5, 100);
			send_item(ACT_TEST, 6'($urandom), 6'($urandom));
			send_item(ACT_REM_V, 6'(chosen[0]), 6'($urandom));
			send_item(ACT_TEST, 6'($urandom), 6'($urandom));
		end
		// full vertex set with the largest minimum member counts
		write_reg(CFG_GAMMA, '0);
		write_reg(CFG_MIN_MEMBERS, 17'd64);
		send_item(ACT_CLEAR, 6'd0, 6'd0);
		for (int v = 0; v < NV; v++)
			send_item(ACT_ADD_V, 6'(v), 6'($urandom));
		send_item(ACT_TEST, 6'd0, 6'd0);
		write_reg(CFG_GAMMA, GAMMA_ONE);
		send_item(ACT_TEST, 6'd0, 6'd0);
		write_reg(CFG_GAMMA, '0);
		write_reg(CFG_MIN_MEMBERS, 17'd127);
		send_item(ACT_TEST, 6'd0, 6'd0);
		write_reg(CFG_GAMMA, GAMMA_RESET);
		write_reg(CFG_MIN_MEMBERS, 17'(MIN_MEMBERS_RESET));
	endtask

	task automatic test_no_idle_stretch();
		idle_pct = 0;
		repeat (4) run_graph_episode();
		idle_pct = 30;
	endtask

	task automatic test_pause_until_drained();
		build_graph(6, 100);
		wait_for_drain();
		send_item(ACT_TEST, 6'($urandom), 6'($urandom));
		send_item(ACT_QUERY, 6'(chosen[0]), 6'($urandom));
		send_item(ACT_REM_V, 6'(chosen[0]), 6'($urandom));
		send_item(ACT_TEST, 6'($urandom), 6'($urandom));
	endtask

	task automatic test_random_graphs();
		while (items_sent < TARGET_ITEMS) begin
			// occasional new register setting between episodes
			if ($urandom_range(3) == 0) begin
				case ($urandom_range(6))
					0:       write_reg(CFG_GAMMA, '0);
					1:       write_reg(CFG_GAMMA, GAMMA_ONE);
					2:       write_reg(CFG_GAMMA, 17'd32768);
					3:       write_reg(CFG_GAMMA, 17'd49152);
					4:       write_reg(CFG_GAMMA, GAMMA_TOP);
					default: write_reg(CFG_GAMMA, 17'($urandom_range(0, 65536)));
				endcase
				if ($urandom_range(9) == 0)
					write_reg(CFG_MIN_MEMBERS, 17'($urandom_range(0, 127)));
				else
					write_reg(CFG_MIN_MEMBERS, 17'($urandom_range(0, 12)));
			end
			run_graph_episode();
		end
	endtask

	// ------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------
	initial begin
		wipe_graph_model();
		cfg_gamma       = GAMMA_RESET;
		cfg_min_members = MIN_MEMBERS_RESET;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_register_sweep();
		test_no_idle_stretch();
		test_pause_until_drained();
		test_random_graphs();
		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("quasi_clique_graph_checker verification clean");
		else
			$display("quasi_clique_graph_checker verification failed");
		$finish;
	end

endmodule

`default_nettype wire
